[sv/srt_pkg.sv]
// shared types and constants of the ascending sort engine
`default_nettype none

package srt_pkg;

    // capacity of the cell chain, one element per cell
    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [COUNT_W-1:0] count_t;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic insert;   // place the broadcast element in order
        logic shift;    // move every element one cell towards the head
    } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/sort_engine_ascending.sv]
// top level of the ascending sort engine built on an insertion cell chain
`default_nettype none

// channel  | dir | ports                      | payload
// ---------+-----+----------------------------+---------------------------------
// input    | in  | s_tvalid s_tready s_tdata  | tdata[31:0] value, tlast last
//          |     | s_tlast                    |
// result   | out | m_tvalid m_tready m_tdata  | tdata[31:0] sorted_value,
//          |     | m_tlast                    | tlast end_of_run
//
// each taken input item is broadcast to every cell and dropped into its
// ordered place while the larger ones move up
// a set drains from the head cell, one item per cycle while the result side
// is ready; s_tready stays low while the set drains
// synchronous active-low reset empties the chain and clears the fill count
// a stall on the result side simply holds the head cell

module sort_engine_ascending (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] value
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast
);

    // drain flag, set once the set is closed
    logic                drain_reg;
    logic                drain_next;
    srt_pkg::count_t     count_reg;
    srt_pkg::count_t     count_next;

    srt_pkg::cell_ctrl_t ctrl;
    srt_pkg::data_t      head_value;
    logic                head_valid;
    logic                second_valid;
    logic                closing;

    assign s_tready    = !drain_reg;
    assign ctrl.insert = s_tvalid && s_tready;
    assign ctrl.shift  = m_tvalid && m_tready;

    // a full chain closes the set as if the item had been marked last
    assign closing = s_tlast ||
                     (count_reg == srt_pkg::COUNT_W'(srt_pkg::MAX_ELEMENTS - 1));

    always_comb begin
        drain_next = drain_reg;
        count_next = count_reg;
        if (ctrl.insert) begin
            if (closing) begin
                drain_next = 1'b1;
                count_next = '0;
            end else begin
                count_next = count_reg + srt_pkg::COUNT_W'(1);
            end
        end else if (ctrl.shift && m_tlast) begin
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            drain_reg <= drain_next;
            count_reg <= count_next;
        end
    end

    srt_chain u_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .new_value    (s_tdata),
        .head_value   (head_value),
        .head_valid   (head_valid),
        .second_valid (second_valid)
    );

    // the head cell is the output register
    assign m_tvalid = drain_reg && head_valid;
    assign m_tdata  = head_value;
    assign m_tlast  = !second_valid;

    // never take an item while results are still leaving
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while set drains");

    // a closed set always yields a result next cycle
    a_close_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.insert && closing) |=> m_tvalid)
        else $error("closed set gave no result");

    // results leave in ascending signed order
    a_ascending: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.shift && !m_tlast) |=>
            (m_tvalid && ($signed(m_tdata) >= $signed($past(m_tdata)))))
        else $error("results out of order");

    // the chain never holds more than its capacity of pending elements
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < srt_pkg::COUNT_W'(srt_pkg::MAX_ELEMENTS))
        else $error("fill count past capacity");

endmodule

`default_nettype wire

[sv/srt_cell.sv]
// one compare-and-hold cell of the insertion chain
`default_nettype none

module srt_cell (
    input  wire               aclk,
    input  wire               aresetn,
    input  srt_pkg::cell_ctrl_t ctrl,
    input  srt_pkg::data_t    new_value,
    input  wire               prev_gt,
    input  srt_pkg::data_t    prev_value,
    input  wire               prev_valid,
    input  srt_pkg::data_t    next_value,
    input  wire               next_valid,
    output srt_pkg::data_t    value,
    output logic              valid,
    output logic              gt
);

    srt_pkg::data_t value_reg;
    srt_pkg::data_t value_next;
    logic           valid_reg;
    logic           valid_next;

    // an empty cell counts as holding plus infinity
    assign gt = !valid_reg || ($signed(value_reg) > $signed(new_value));

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            value_next = next_value;
            valid_next = next_valid;
        end else if (ctrl.insert) begin
            if (gt) begin
                value_next = prev_gt ? prev_value : new_value;
            end
            valid_next = valid_reg | prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

[sv/srt_chain.sv]
// row of sort cells, head cell holds the smallest element
`default_nettype none

module srt_chain (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  srt_pkg::cell_ctrl_t ctrl,
    input  srt_pkg::data_t      new_value,
    output srt_pkg::data_t      head_value,
    output logic                head_valid,
    output logic                second_valid
);

    srt_pkg::data_t value [srt_pkg::MAX_ELEMENTS];
    logic           valid [srt_pkg::MAX_ELEMENTS];
    logic           gt    [srt_pkg::MAX_ELEMENTS];

    genvar i;
    generate
        for (i = 0; i < srt_pkg::MAX_ELEMENTS; i++) begin : g_cell
            logic           p_gt;
            srt_pkg::data_t p_value;
            logic           p_valid;
            srt_pkg::data_t n_value;
            logic           n_valid;

            if (i == 0) begin : g_head
                assign p_gt    = 1'b0;
                assign p_value = '0;
                assign p_valid = 1'b1;
            end else begin : g_body
                assign p_gt    = gt[i-1];
                assign p_value = value[i-1];
                assign p_valid = valid[i-1];
            end

            if (i == srt_pkg::MAX_ELEMENTS - 1) begin : g_tail
                assign n_value = '0;
                assign n_valid = 1'b0;
            end else begin : g_inner
                assign n_value = value[i+1];
                assign n_valid = valid[i+1];
            end

            srt_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_value  (new_value),
                .prev_gt    (p_gt),
                .prev_value (p_value),
                .prev_valid (p_valid),
                .next_value (n_value),
                .next_valid (n_valid),
                .value      (value[i]),
                .valid      (valid[i]),
                .gt         (gt[i])
            );
        end
    endgenerate

    assign head_value   = value[0];
    assign head_valid   = valid[0];
    assign second_valid = valid[1];

endmodule

`default_nettype wire

[tb/sv/sort_engine_ascending_tb.sv]
// self-checking testbench of the ascending sort engine on its two item streams
`timescale 1ns / 100ps

module sort_engine_ascending_tb;

    // one offered input item, with the sorted result typed in where it is obvious
    typedef struct packed {
        srt_pkg::data_t value;
        logic           last;
        logic           typed;        // 1: single-item set, result written out below
        srt_pkg::data_t typed_value;
    } stim_row_t;

    // one sorted result as it should leave the block
    typedef struct packed {
        srt_pkg::data_t sorted_value;
        logic           end_of_run;
    } sorted_item_t;

    // how the result side behaves over one stretch of cycles
    typedef enum int {
        RX_STEADY,
        RX_CHOPPY,
        RX_ALTERNATE
    } rx_mode_t;

    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_OFF     = 300;   // long result-side stall right after reset
    localparam int SETTLE       = 20;    // quiet cycles after the last result
    localparam int DRAIN_LIMIT  = 20000;
    localparam int MAX_REPORTS  = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] value
    logic        s_tlast;    // last
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] sorted_value
    logic        m_tlast;    // end_of_run

    // items offered but not yet taken, in offering order
    stim_row_t      offered_rows [$];
    // elements of the set being collected, in arrival order
    srt_pkg::data_t held_set [$];
    // sorted run worked out for the latest input item
    sorted_item_t   predicted_run [$];
    // sorted results still to come out of the block, oldest first
    sorted_item_t   sorted_due [$];

    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;

    stim_row_t directed_rows [20];

    sort_engine_ascending i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // adds one element to the set; on a closing element the whole set comes
    // out in ascending signed order, equal values all kept, the last one marked
    function automatic void sort_accept(input srt_pkg::data_t value, input logic closes);
        int unsigned  slot;
        sorted_item_t entry;
        predicted_run.delete();
        held_set.push_back(value);
        // a full store closes the set whatever the last flag says
        if (!closes && held_set.size() < srt_pkg::MAX_ELEMENTS)
            return;
        foreach (held_set[i]) begin
            slot = 0;
            while (slot < predicted_run.size() &&
                   $signed(predicted_run[slot].sorted_value) <= $signed(held_set[i]))
                slot++;
            entry.sorted_value = held_set[i];
            entry.end_of_run   = 1'b0;
            predicted_run.insert(slot, entry);
        end
        predicted_run[predicted_run.size() - 1].end_of_run = 1'b1;
        held_set.delete();
    endfunction

    // offers one item and returns once it is taken; the sender works in bursts
    // with random gaps, and valid stays high from one item of a burst to the next
    task automatic offer_item(input stim_row_t row);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        offered_rows.push_back(row);
        s_tvalid <= 1'b1;
        s_tdata  <= row.value;
        s_tlast  <= row.last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // input side: reset, directed table, random sets, then wait for the drain
    initial begin : input_side
        stim_row_t   row;
        int unsigned random_items;
        int unsigned sets_done;
        int unsigned set_kind;
        int unsigned set_len;
        int unsigned drain_wait;
        logic        mark_last;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;

        // single-item sets first: the result is the item itself, marked last
        directed_rows = '{
            '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},  // most negative
            '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},  // most positive
            '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},  // minus one
            // both extremes, zero and the signs mixed
            '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
            '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
            // repeated values must all come back
            '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
            '{32'hFFFF_FFFB, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0005, 1'b1, 1'b0, 32'h0},
            // arriving in descending order
            '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
            '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
            // equal pair, marker on the second
            '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
            '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
            // alternating bit patterns
            '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
            '{32'h5555_5555, 1'b1, 1'b0, 32'h0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i]);

        // random sets: mostly short ones, some long, some that fill the store
        // with no marker, and now and then one left open so it runs into the next
        random_items = 0;
        sets_done    = 0;
        row.typed       = 1'b0;
        row.typed_value = '0;
        while (random_items < RANDOM_ITEMS) begin
            // the first random set fills the store without a last marker
            set_kind = (sets_done == 0) ? 8 : $urandom_range(0, 9);
            case (set_kind)
                0, 1, 2, 3, 4, 5: begin
                    set_len   = $urandom_range(1, 8);
                    mark_last = 1'b1;
                end
                6, 7: begin
                    set_len   = $urandom_range(9, 40);
                    mark_last = ($urandom_range(0, 5) != 0);
                end
                8: begin
                    set_len   = srt_pkg::MAX_ELEMENTS;
                    mark_last = 1'b0;
                end
                default: begin
                    set_len   = $urandom_range(41, srt_pkg::MAX_ELEMENTS);
                    mark_last = 1'b1;
                end
            endcase
            for (int unsigned k = 0; k < set_len; k++) begin
                case ($urandom_range(0, 7))
                    0, 1, 2: row.value = $urandom;
                    3, 4:    row.value = srt_pkg::data_t'($urandom_range(0, 16))
                                         - srt_pkg::data_t'(8);
                    5: begin
                        case ($urandom_range(0, 3))
                            0:       row.value = 32'h8000_0000;
                            1:       row.value = 32'h7FFF_FFFF;
                            2:       row.value = 32'h0000_0000;
                            default: row.value = 32'hFFFF_FFFF;
                        endcase
                    end
                    6:       row.value = $urandom | 32'h8000_0000;
                    default: row.value = $urandom & 32'h7FFF_FFFF;
                endcase
                row.last = mark_last && (k == set_len - 1);
                offer_item(row);
                random_items++;
            end
            sets_done++;
        end

        // close whatever is still open
        row.value = $urandom;
        row.last  = 1'b1;
        offer_item(row);
        s_tvalid <= 1'b0;
        // let the scoreboard book the closing item before looking at the queue
        @(posedge aclk);

        drain_wait = 0;
        while (sorted_due.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (SETTLE) @(posedge aclk);

        if (sorted_due.size() != 0) begin
            mismatch_count++;
            $display("%0t: sorted items left expected 0 actual %0d", $time, sorted_due.size());
        end
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: a long hold-off while the sender keeps offering, so the
    // block drains into a stalled output and holds its input off, then
    // stretches of steady, choppy and alternating readiness
    initial begin : result_side
        rx_mode_t    rx_mode;
        int unsigned stretch;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
        forever begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            stretch = $urandom_range(10, 80);
            repeat (stretch) begin
                case (rx_mode)
                    RX_STEADY:  m_tready <= 1'b1;
                    RX_CHOPPY:  m_tready <= ($urandom_range(0, 1) == 1);
                    default:    m_tready <= ~m_tready;
                endcase
                @(posedge aclk);
            end
        end
    end

    // prediction on every taken input item, check on every taken result;
    // input first so a result in the same edge finds its expectation
    always @(posedge aclk) begin : scoreboard
        stim_row_t    row;
        sorted_item_t due;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                row = offered_rows.pop_front();
                sort_accept(s_tdata, s_tlast);
                if (row.typed) begin
                    due.sorted_value = row.typed_value;
                    due.end_of_run   = 1'b1;
                    sorted_due.push_back(due);
                end else begin
                    foreach (predicted_run[i])
                        sorted_due.push_back(predicted_run[i]);
                end
            end
            if (m_tvalid && m_tready) begin
                if (sorted_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected item, expected none, actual %h last %b",
                                 $time, m_tdata, m_tlast);
                end else begin
                    due = sorted_due.pop_front();
                    if (m_tdata !== due.sorted_value) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: sorted_value expected %h actual %h",
                                     $time, due.sorted_value, m_tdata);
                    end
                    if (m_tlast !== due.end_of_run) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: end_of_run expected %b actual %b",
                                     $time, due.end_of_run, m_tlast);
                    end
                end
            end
        end
    end

    // watchdog, well beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
sv/srt_pkg.sv
sv/srt_cell.sv
sv/srt_chain.sv
sv/sort_engine_ascending.sv
tb/sv/sort_engine_ascending_tb.sv
